// File: hdl/sfi_pkg.sv
// Shared types, codes and constants of the step function integral block.
`default_nettype none
package sfi_pkg;

	localparam int X_W          = 32;
	localparam int IDX_W        = 6;
	localparam int OUT_W        = 64;
	localparam int PU_W         = 7;
	localparam int TOL_W        = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int MAX_POINTS_DEF = 64;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL     = 1'd1;

	localparam logic signed [OUT_W-1:0] ACC_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] ACC_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic signed [X_W-1:0] plo;
		logic signed [X_W-1:0] phi;
		logic signed [X_W-1:0] lev;
	} piece_t;

	typedef struct packed {
		logic                    done;
		logic                    flag;
		logic signed [OUT_W-1:0] value;
	} acc_res_t;

endpackage
`default_nettype wire

// File: hdl/sfi_ifs.sv
// Request and result channel interfaces of the step function integral block.
`default_nettype none
interface sfi_req_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [sfi_pkg::IDX_W-1:0]      point_index;
	logic signed [sfi_pkg::X_W-1:0] grid_abscissa;
	logic signed [sfi_pkg::X_W-1:0] grid_level;
	logic signed [sfi_pkg::X_W-1:0] bound_a;
	logic signed [sfi_pkg::X_W-1:0] bound_b;

	modport source (
		output valid, req_type, point_index, grid_abscissa, grid_level, bound_a, bound_b,
		input  ready
	);
	modport sink (
		input  valid, req_type, point_index, grid_abscissa, grid_level, bound_a, bound_b,
		output ready
	);
endinterface

interface sfi_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [sfi_pkg::OUT_W-1:0] integral_value;
	logic                             saturated;

	modport source (
		output valid, integral_value, saturated,
		input  ready
	);
	modport sink (
		input  valid, integral_value, saturated,
		output ready
	);
endinterface
`default_nettype wire

// File: hdl/sfi_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/sfi_accum.sv
// Piece clipping, length times level product and saturating accumulation.
`default_nettype none
module sfi_accum (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           clear,
	input  wire sfi_pkg::piece_t                piece,
	input  wire logic signed [sfi_pkg::X_W-1:0] lo,
	input  wire logic signed [sfi_pkg::X_W-1:0] hi,
	output sfi_pkg::acc_res_t                   res
);
	logic                               v_s2, last_s2;
	logic signed [sfi_pkg::X_W-1:0]     plo_s2, phi_s2, lev_s2;
	logic                               v_s3, last_s3;
	logic [sfi_pkg::X_W-1:0]            len_s3;
	logic signed [sfi_pkg::X_W-1:0]     lev_s3;
	logic                               v_s4, last_s4;
	logic signed [sfi_pkg::OUT_W-1:0]   prod_s4;
	logic signed [sfi_pkg::OUT_W-1:0]   acc_q;
	logic                               flag_q, done_q;

	logic signed [sfi_pkg::X_W-1:0]     s_start, s_end;
	logic signed [sfi_pkg::X_W:0]       s_diff;
	logic [sfi_pkg::X_W-1:0]            len_c;
	logic signed [sfi_pkg::OUT_W:0]     prod_c;
	logic signed [sfi_pkg::OUT_W:0]     sum_c;
	logic signed [sfi_pkg::OUT_W-1:0]   acc_c;
	logic                               clip_c;

	always_comb begin
		s_start = (plo_s2 > lo) ? plo_s2 : lo;
		s_end   = (phi_s2 < hi) ? phi_s2 : hi;
		s_diff  = {s_end[sfi_pkg::X_W-1], s_end} - {s_start[sfi_pkg::X_W-1], s_start};
		len_c   = (s_end > s_start) ? s_diff[sfi_pkg::X_W-1:0] : '0;
	end

	assign prod_c = $signed({1'b0, len_s3}) * lev_s3;

	always_comb begin
		sum_c  = {acc_q[sfi_pkg::OUT_W-1], acc_q} + {prod_s4[sfi_pkg::OUT_W-1], prod_s4};
		clip_c = sum_c[sfi_pkg::OUT_W] != sum_c[sfi_pkg::OUT_W-1];
		if (clip_c) begin
			acc_c = sum_c[sfi_pkg::OUT_W] ? sfi_pkg::ACC_MIN : sfi_pkg::ACC_MAX;
		end else begin
			acc_c = sum_c[sfi_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			acc_q  <= '0;
			flag_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s2 <= piece.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (clear) begin
				acc_q  <= '0;
				flag_q <= 1'b0;
				done_q <= 1'b0;
			end else begin
				done_q <= v_s4 && last_s4;
				if (v_s4) begin
					acc_q  <= acc_c;
					flag_q <= flag_q | clip_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= piece.last;
		plo_s2  <= piece.plo;
		phi_s2  <= piece.phi;
		lev_s2  <= piece.lev;
		last_s3 <= last_s2;
		len_s3  <= len_c;
		lev_s3  <= lev_s2;
		last_s4 <= last_s3;
		prod_s4 <= prod_c[sfi_pkg::OUT_W-1:0];
	end

	assign res.done  = done_q;
	assign res.flag  = flag_q;
	assign res.value = acc_q;
endmodule
`default_nettype wire

// File: hdl/step_function_integral.sv
// Step function integral block: loads grid points, integrates Q16.16 step functions.
// A load item is written straight into the abscissa and level RAMs. A query item
// passes through a bound check, a walk with one RAM read per grid point (n being
// the clamped points in use), the RAM read register, the closing of the top piece,
// a four-stage clip, multiply and saturating-add pipeline, the exit from the wait
// state and the output register. The next item can be taken in the cycle that the
// result shows. Bounds within the tolerance skip the walk and go from the bound
// check straight to the result state. One item is in work at a time. A new item is
// taken while the previous result still waits, but a finished query holds in its
// result state until the output register is free.
`default_nettype none
module step_function_integral #(
	parameter int MAX_POINTS = sfi_pkg::MAX_POINTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	sfi_req_if.sink                                req,
	sfi_res_if.source                              res,
	input  wire logic                              cfg_we,
	input  wire logic [sfi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sfi_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int NB  = $clog2(MAX_POINTS + 1);
	localparam int NW  = (NB > sfi_pkg::PU_W) ? NB : sfi_pkg::PU_W;

	sfi_pkg::state_t state_q, state_d;

	logic [sfi_pkg::PU_W-1:0]        pu_q;
	logic [sfi_pkg::TOL_W-1:0]       tol_q;
	logic [NW-1:0]                   n_q, n_c, pu_ext;
	logic signed [sfi_pkg::X_W-1:0]  a_q, b_q, lo_q, hi_q;
	logic                            neg_q, zero_q;
	logic [AW-1:0]                   k_q;
	logic                            issue_last;

	logic                            req_ready, accept, load_we, idx_ok;
	logic                            rd_en, acc_clear, res_load;

	logic signed [sfi_pkg::X_W:0]    d_c;
	logic [sfi_pkg::X_W:0]           absd_c;
	logic                            zero_c;

	logic [sfi_pkg::X_W-1:0]         rx_s1, rl_s1;
	logic                            rv_s1, rfirst_s1, rlast_s1;
	logic signed [sfi_pkg::X_W-1:0]  px_q, pl_q;
	logic                            pfirst_q, fin_q;

	sfi_pkg::piece_t                 piece;
	sfi_pkg::acc_res_t               acc_res;

	logic                            res_valid_q, res_sat_q;
	logic signed [sfi_pkg::OUT_W-1:0] res_val_q;
	logic signed [sfi_pkg::OUT_W-1:0] fin_val_c;
	logic                            fin_sat_c;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pu_q  <= sfi_pkg::PU_W'(1);
			tol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfi_pkg::CFG_POINTS_IN_USE: pu_q  <= cfg_data[sfi_pkg::PU_W-1:0];
				sfi_pkg::CFG_MATCH_TOL:     tol_q <= cfg_data[sfi_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pu_ext = NW'(pu_q);
		if (pu_ext == '0) begin
			n_c = NW'(1);
		end else if (pu_ext > NW'(MAX_POINTS)) begin
			n_c = NW'(MAX_POINTS);
		end else begin
			n_c = pu_ext;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfi_pkg::ST_IDLE: begin
				if (req.valid && req.req_type == sfi_pkg::REQ_QUERY) state_d = sfi_pkg::ST_CHECK;
			end
			sfi_pkg::ST_CHECK: begin
				state_d = zero_c ? sfi_pkg::ST_RESULT : sfi_pkg::ST_WALK;
			end
			sfi_pkg::ST_WALK: begin
				if (issue_last) state_d = sfi_pkg::ST_WAIT;
			end
			sfi_pkg::ST_WAIT: begin
				if (acc_res.done) state_d = sfi_pkg::ST_RESULT;
			end
			sfi_pkg::ST_RESULT: begin
				if (!res_valid_q || res.ready) state_d = sfi_pkg::ST_IDLE;
			end
			default: state_d = sfi_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		acc_clear = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			sfi_pkg::ST_IDLE:   req_ready = 1'b1;
			sfi_pkg::ST_CHECK:  acc_clear = 1'b1;
			sfi_pkg::ST_WALK:   rd_en     = 1'b1;
			sfi_pkg::ST_WAIT:   ;
			sfi_pkg::ST_RESULT: res_load  = !res_valid_q || res.ready;
			default: ;
		endcase
	end

	assign req.ready  = req_ready;
	assign accept     = req.valid && req_ready;
	assign idx_ok     = NW'(req.point_index) < NW'(MAX_POINTS);
	assign load_we    = accept && req.req_type == sfi_pkg::REQ_LOAD && idx_ok;
	assign issue_last = NW'(k_q) == n_q - NW'(1);

	always_comb begin
		d_c    = {b_q[sfi_pkg::X_W-1], b_q} - {a_q[sfi_pkg::X_W-1], a_q};
		absd_c = d_c[sfi_pkg::X_W] ? 33'(-d_c) : 33'(d_c);
		zero_c = absd_c < 33'(tol_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sfi_pkg::ST_IDLE;
			k_q       <= '0;
			rv_s1     <= 1'b0;
			fin_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc_clear) begin
				k_q <= '0;
			end else if (rd_en) begin
				k_q <= k_q + AW'(1);
			end
			rv_s1 <= rd_en;
			fin_q <= rv_s1 && rlast_s1;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= req.bound_a;
			b_q <= req.bound_b;
			n_q <= n_c;
		end
		if (acc_clear) begin
			zero_q <= zero_c;
			neg_q  <= d_c[sfi_pkg::X_W];
			lo_q   <= d_c[sfi_pkg::X_W] ? b_q : a_q;
			hi_q   <= d_c[sfi_pkg::X_W] ? a_q : b_q;
		end
		rfirst_s1 <= k_q == '0;
		rlast_s1  <= issue_last;
		if (rv_s1) begin
			px_q     <= rx_s1;
			pl_q     <= rl_s1;
			pfirst_q <= rfirst_s1;
		end
		if (res_load) begin
			res_val_q <= fin_val_c;
			res_sat_q <= fin_sat_c;
		end
	end

	sfi_ram #(.WIDTH(sfi_pkg::X_W), .DEPTH(MAX_POINTS)) u_abscissa_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(req.point_index)),
		.wdata (req.grid_abscissa),
		.re    (rd_en),
		.raddr (k_q),
		.rdata (rx_s1)
	);

	sfi_ram #(.WIDTH(sfi_pkg::X_W), .DEPTH(MAX_POINTS)) u_level_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(req.point_index)),
		.wdata (req.grid_level),
		.re    (rd_en),
		.raddr (k_q),
		.rdata (rl_s1)
	);

	// piece k-1 closes when entry k arrives; the top piece closes once fin_q registers the last entry's arrival
	always_comb begin
		piece.valid = (rv_s1 && !rfirst_s1) || fin_q;
		piece.last  = fin_q;
		piece.plo   = pfirst_q ? lo_q : px_q;
		piece.phi   = fin_q ? hi_q : $signed(rx_s1);
		piece.lev   = pl_q;
	end

	sfi_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (acc_clear),
		.piece  (piece),
		.lo     (lo_q),
		.hi     (hi_q),
		.res    (acc_res)
	);

	always_comb begin
		if (zero_q) begin
			fin_val_c = '0;
			fin_sat_c = 1'b0;
		end else if (neg_q && acc_res.value == sfi_pkg::ACC_MIN) begin
			fin_val_c = sfi_pkg::ACC_MAX;
			fin_sat_c = 1'b1;
		end else if (neg_q) begin
			fin_val_c = -acc_res.value;
			fin_sat_c = acc_res.flag;
		end else begin
			fin_val_c = acc_res.value;
			fin_sat_c = acc_res.flag;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.integral_value = res_val_q;
	assign res.saturated      = res_sat_q;

	a_no_piece_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(rv_s1 && fin_q))
		else $error("read data and closing piece in the same cycle");

	a_read_follows_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfi_pkg::ST_WALK |=> rv_s1)
		else $error("walk read without data next cycle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		acc_res.done |-> state_q == sfi_pkg::ST_WAIT)
		else $error("accumulator done outside wait");

	a_result_from_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == sfi_pkg::ST_RESULT))
		else $error("result raised outside result state");
endmodule
`default_nettype wire
